@@ hdl/rqpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rqpd_pkg
// Shared constants, command codes and control structs of the ring queue with
// peek and delete.
// ----------------------------------------------------------------------------
package rqpd_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned PtrW    = $clog2(Depth);
  localparam int unsigned ActW    = 8;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CountW  = 4;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 3;

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [ActW-1:0] act_t;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  // register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_EMPTY_MARKER = 1'b0,
    REG_NONE         = 1'b1
  } reg_idx_e;

  // one access to the slot memory
  typedef struct packed {
    logic we;
    logic re;
    ptr_t addr;
    act_t wdata;
  } ram_req_t;

  // what the result of one transaction still needs once the read data is back
  typedef struct packed {
    logic              accepted;
    logic              use_mem;
    logic [CountW-1:0] count;
    act_t              marker;
  } res_info_t;

endpackage

@@ hdl/rqpd_slot_ram.sv @@
// ----------------------------------------------------------------------------
// rqpd_slot_ram
// Single-port slot store: one write or one read per cycle, read data
// registered.
// ----------------------------------------------------------------------------
module rqpd_slot_ram (
  input  logic               clk_i,
  input  rqpd_pkg::ram_req_t req_i,
  output rqpd_pkg::act_t     rdata_o
);

  rqpd_pkg::act_t mem_q [rqpd_pkg::Depth];
  rqpd_pkg::act_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/rqpd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rqpd_ctrl
// Pointer keeper and command decoder: builds the slot access of a
// transaction and the result fields known at accept time.
// ----------------------------------------------------------------------------
module rqpd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  rqpd_pkg::cmd_e                cmd_i,
  input  rqpd_pkg::act_t                action_i,
  input  logic [rqpd_pkg::PosW-1:0]     position_i,
  input  rqpd_pkg::act_t                marker_i,
  output rqpd_pkg::ram_req_t            req_o,
  output rqpd_pkg::res_info_t           info_o
);

  rqpd_pkg::ptr_t wp_q, wp_d;
  rqpd_pkg::ptr_t rp_q, rp_d;
  rqpd_pkg::ptr_t held;
  rqpd_pkg::ptr_t pos_addr;
  logic           full;
  logic           empty;
  logic           pos_live;
  logic           pos_in_range;

  assign held         = rqpd_pkg::ptr_t'(wp_q - rp_q);
  assign full         = rqpd_pkg::ptr_t'(wp_q + 1'b1) == rp_q;
  assign empty        = wp_q == rp_q;
  assign pos_addr     = rqpd_pkg::ptr_t'(rp_q + rqpd_pkg::ptr_t'(position_i));
  assign pos_live     = 32'(position_i) < 32'(held);
  assign pos_in_range = 32'(position_i) < rqpd_pkg::Depth;

  always_comb begin
    wp_d          = wp_q;
    rp_d          = rp_q;
    req_o.we      = 1'b0;
    req_o.re      = 1'b0;
    req_o.addr    = pos_addr;
    req_o.wdata   = marker_i;
    info_o.accepted = 1'b0;
    info_o.use_mem  = 1'b0;
    info_o.marker   = marker_i;
    unique case (cmd_i)
      rqpd_pkg::CMD_PUSH: begin
        req_o.addr  = wp_q;
        req_o.wdata = action_i;
        if (!full) begin
          req_o.we        = accept_i;
          wp_d            = rqpd_pkg::ptr_t'(wp_q + 1'b1);
          info_o.accepted = 1'b1;
        end
      end
      rqpd_pkg::CMD_POP: begin
        req_o.addr = rp_q;
        if (!empty) begin
          req_o.re       = accept_i;
          rp_d           = rqpd_pkg::ptr_t'(rp_q + 1'b1);
          info_o.use_mem = 1'b1;
        end
      end
      rqpd_pkg::CMD_PEEK: begin
        if (pos_live) begin
          req_o.re       = accept_i;
          info_o.use_mem = 1'b1;
        end
      end
      rqpd_pkg::CMD_DELETE: begin
        // overwrite even past the count; the slot is simply dead
        req_o.we = accept_i && pos_in_range;
      end
      default: ;
    endcase
    info_o.count = rqpd_pkg::CountW'(rqpd_pkg::ptr_t'(wp_d - rp_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else if (accept_i) begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

endmodule

@@ hdl/ring_queue_with_peek_delete_core.sv @@
// ----------------------------------------------------------------------------
// ring_queue_with_peek_delete_core
// Circular queue of action codes with push, pop, peek and delete commands,
// holding up to Depth-1 entries in a single-port slot memory.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------
//  in      | in_valid_i/in_ready_o   | command_i, action_in_i, position_i
//  out     | out_valid_o/out_ready_i | accepted_o, action_out_o, count_o
//  cfg     | psel/penable/pwrite     | paddr, pwdata, prdata
//
// From accept to result, the slot memory is accessed at the accept edge
// and its registered read data is steered into the output register once
// the pending transaction can move on. One transaction can be accepted per
// cycle while the output side keeps up. Reset clears both pointers and the
// empty marker; slot contents stay undefined. A stalled output holds the
// pending transaction in place and drops in_ready_o.
// ----------------------------------------------------------------------------
module ring_queue_with_peek_delete_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rqpd_pkg::CmdW-1:0]         command_i,
  input  logic [rqpd_pkg::ActW-1:0]         action_in_i,
  input  logic [rqpd_pkg::PosW-1:0]         position_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              accepted_o,
  output logic [rqpd_pkg::ActW-1:0]         action_out_o,
  output logic [rqpd_pkg::CountW-1:0]       count_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rqpd_pkg::AddrW-1:0]        paddr,
  input  logic [rqpd_pkg::DataW-1:0]        pwdata,
  output logic [rqpd_pkg::DataW-1:0]        prdata,
  output logic                              pready
);

  rqpd_pkg::act_t      marker_q;
  rqpd_pkg::reg_idx_e  reg_idx;
  logic                cfg_wr;

  logic                in_accept;
  logic                move;
  rqpd_pkg::ram_req_t  ram_req;
  rqpd_pkg::act_t      rdata;
  rqpd_pkg::res_info_t info;

  logic                pend_q;
  rqpd_pkg::res_info_t pend_info_q;
  logic                out_valid_q;
  logic                out_acc_q;
  rqpd_pkg::act_t      out_act_q;
  logic [rqpd_pkg::CountW-1:0] out_count_q;

  // configuration register
  assign pready  = 1'b1;
  assign reg_idx = rqpd_pkg::reg_idx_e'(paddr[rqpd_pkg::AddrW-1]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= '0;
    end else if (cfg_wr && reg_idx == rqpd_pkg::REG_EMPTY_MARKER) begin
      marker_q <= pwdata[rqpd_pkg::ActW-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      rqpd_pkg::REG_EMPTY_MARKER: prdata = rqpd_pkg::DataW'(marker_q);
      default:                    prdata = '0;
    endcase
  end

  // datapath
  assign move       = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || move;
  assign in_accept  = in_valid_i && in_ready_o;

  rqpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .cmd_i      (rqpd_pkg::cmd_e'(command_i)),
    .action_i   (action_in_i),
    .position_i (position_i),
    .marker_i   (marker_q),
    .req_o      (ram_req),
    .info_o     (info)
  );

  rqpd_slot_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_info_q <= info;
    end
    if (move) begin
      out_acc_q   <= pend_info_q.accepted;
      out_act_q   <= pend_info_q.use_mem ? rdata : pend_info_q.marker;
      out_count_q <= pend_info_q.count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = out_acc_q;
  assign action_out_o = out_act_q;
  assign count_o      = out_count_q;

  // a pending transaction stays until it moves to the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !move |=> pend_q)
    else $error("pending transaction lost");

  // only a push can be reported as accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && command_i != rqpd_pkg::CMD_PUSH |=> !pend_info_q.accepted)
    else $error("accepted set on a non-push command");

  // the slot memory never sees a read and a write in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re))
    else $error("slot memory read and write collide");

  // a result marked as memory data always had its slot read issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && info.use_mem |-> ram_req.re)
    else $error("memory result without slot read");

endmodule
